/* rtl/nucleotide_error_injector_macros.svh */
// ----------------------------------------------------------------------------
// Nucleotide error injector assertion macros
// Shared concurrent check forms for the injector modules.
// ----------------------------------------------------------------------------
`ifndef NUCLEOTIDE_ERROR_INJECTOR_MACROS_SVH
`define NUCLEOTIDE_ERROR_INJECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define NEI_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nucleotide_error_injector: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define NEI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nucleotide_error_injector: next-cycle check failed");

`endif

/* rtl/nei_pkg.sv */
// ----------------------------------------------------------------------------
// Nucleotide error injector package
// Widths, generator constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package nei_pkg;

  localparam int BASE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int STATE_W    = 48;
  localparam int LIMIT_W    = 49;
  localparam int SEED_W     = 32;
  localparam int CFG_DATA_W = 49;
  localparam int CFG_IDX_W  = 2;

  // Generator multiplier 0x5DEECE66D split into a 32-bit low and 3-bit high part
  localparam logic [31:0]        LCG_A_LO = 32'hDEEC_E66D;
  localparam logic [2:0]         LCG_A_HI = 3'h5;
  localparam logic [STATE_W-1:0] LCG_INC  = 48'h0000_0000_000B;
  localparam logic [15:0]        SEED_LOW = 16'h330E;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INSERTION = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELETION  = 2'd3;

  // Edit kind codes
  localparam logic [KIND_W-1:0] KIND_COPY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUB  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INS  = 2'd2;

  localparam logic [BASE_W-1:0] BASE_A = 8'h41;
  localparam logic [BASE_W-1:0] BASE_C = 8'h43;
  localparam logic [BASE_W-1:0] BASE_G = 8'h47;
  localparam logic [BASE_W-1:0] BASE_T = 8'h54;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DECIDE,
    S_PICK,
    S_TAIL
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DR_FIRST,
    DR_SUB,
    DR_INS
  } draw_mode_t;

  typedef struct packed {
    logic              load_base;
    logic              mul_en;
    logic              add_en;
    logic              emit_en;
    logic              emit_rand;
    logic [KIND_W-1:0] emit_kind;
    logic              emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lt_mis;
    logic lt_ins;
    logic lt_del;
    logic base_match;
    logic slot_free;
  } ctrl_sts_t;

  // Top two draw bits pick the base
  function automatic logic [BASE_W-1:0] quarter_base(input logic [1:0] q);
    logic [BASE_W-1:0] b;
    unique case (q)
      2'd0:    b = BASE_A;
      2'd1:    b = BASE_C;
      2'd2:    b = BASE_G;
      default: b = BASE_T;
    endcase
    return b;
  endfunction

endpackage

/* rtl/nei_datapath.sv */
// ----------------------------------------------------------------------------
// Nucleotide error injector datapath
// Generator state with a multiply step and then an add step, limit registers,
// threshold compares and the result output register.
// ----------------------------------------------------------------------------
`include "nucleotide_error_injector_macros.svh"

module nei_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [nei_pkg::BASE_W-1:0]    in_base_in,
  input  logic                          cfg_wr_en,
  input  logic [nei_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nei_pkg::CFG_DATA_W-1:0] cfg_data,
  input  nei_pkg::ctrl_cmd_t            cmd,
  output nei_pkg::ctrl_sts_t            sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nei_pkg::BASE_W-1:0]    out_base_out,
  output logic [nei_pkg::KIND_W-1:0]    out_edit_kind,
  output logic                          out_run_end
);
  import nei_pkg::*;

  logic [STATE_W-1:0] rng_state_r, rng_state_nxt;
  logic [STATE_W-1:0] prod_r;
  logic [15:0]        cross_r;
  logic [LIMIT_W-1:0] mis_lim_r, ins_lim_r, del_lim_r;
  logic [BASE_W-1:0]  base_r;
  logic               out_valid_r, out_valid_nxt;
  logic [BASE_W-1:0]  out_base_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic               out_last_r;

  logic [63:0]        mul_lo;
  logic [31:0]        mul_x1;
  logic [18:0]        mul_x2;
  logic [15:0]        cross_nxt;
  logic [LIMIT_W-1:0] draw_ext;
  logic [BASE_W-1:0]  rand_base;

  // Low 48 bits of state * multiplier: the cross terms only reach bits 47:32
  assign mul_lo    = rng_state_r[31:0] * LCG_A_LO;
  assign mul_x1    = rng_state_r[47:32] * LCG_A_LO[15:0];
  assign mul_x2    = rng_state_r[15:0] * LCG_A_HI;
  assign cross_nxt = mul_x1[15:0] + mul_x2[15:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r  <= mul_lo[STATE_W-1:0];
      cross_r <= cross_nxt;
    end
  end

  always_comb begin
    rng_state_nxt = rng_state_r;
    if (cfg_wr_en && cfg_index == CFG_SEED) begin
      rng_state_nxt = {cfg_data[SEED_W-1:0], SEED_LOW};
    end else if (cmd.add_en) begin
      rng_state_nxt = prod_r + {cross_r, 32'h0} + LCG_INC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_state_r <= {{(STATE_W-16){1'b0}}, SEED_LOW};
      mis_lim_r   <= '0;
      ins_lim_r   <= '0;
      del_lim_r   <= '0;
    end else begin
      rng_state_r <= rng_state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_SEED:      ;
          CFG_MISMATCH:  mis_lim_r <= cfg_data[LIMIT_W-1:0];
          CFG_INSERTION: ins_lim_r <= cfg_data[LIMIT_W-1:0];
          CFG_DELETION:  del_lim_r <= cfg_data[LIMIT_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_base) begin
      base_r <= in_base_in;
    end
  end

  assign draw_ext  = {1'b0, rng_state_r};
  assign rand_base = quarter_base(rng_state_r[STATE_W-1 -: 2]);

  assign sts.lt_mis     = draw_ext < mis_lim_r;
  assign sts.lt_ins     = draw_ext < ins_lim_r;
  assign sts.lt_del     = draw_ext < del_lim_r;
  assign sts.base_match = rand_base == base_r;
  assign sts.slot_free  = !out_valid_r || out_ready;

  // Output register: load on emit, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      out_base_r <= cmd.emit_rand ? rand_base : base_r;
      out_kind_r <= cmd.emit_kind;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_base_out  = out_base_r;
  assign out_edit_kind = out_kind_r;
  assign out_run_end   = out_last_r;

  `NEI_ASSERT_HOLDS(a_emit_has_slot, clk, rst_n, cmd.emit_en, sts.slot_free)
  `NEI_ASSERT_NEXT(a_sub_differs, clk, rst_n, cmd.emit_en && cmd.emit_kind == KIND_SUB, out_base_r != base_r)
  `NEI_ASSERT_NEXT(a_seed_low, clk, rst_n, cfg_wr_en && cfg_index == CFG_SEED, rng_state_r[15:0] == SEED_LOW)

endmodule

/* rtl/nei_ctrl.sv */
// ----------------------------------------------------------------------------
// Nucleotide error injector controller
// Sequences generator steps, threshold decision, substitution retries and
// result emission for one item at a time.
// ----------------------------------------------------------------------------
`include "nucleotide_error_injector_macros.svh"

module nei_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nei_pkg::ctrl_sts_t sts,
  output nei_pkg::ctrl_cmd_t cmd
);
  import nei_pkg::*;

  ctrl_state_t state_r, state_nxt;
  draw_mode_t  mode_r, mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= DR_FIRST;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MUL;
          mode_nxt  = DR_FIRST;
        end
      end
      S_MUL: state_nxt = S_ADD;
      S_ADD: state_nxt = (mode_r == DR_FIRST) ? S_DECIDE : S_PICK;
      S_DECIDE: begin
        if (sts.lt_mis) begin
          state_nxt = S_MUL;
          mode_nxt  = DR_SUB;
        end else if (sts.lt_ins) begin
          state_nxt = S_MUL;
          mode_nxt  = DR_INS;
        end else if (sts.lt_del) begin
          state_nxt = S_IDLE;
        end else if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_PICK: begin
        unique case (mode_r)
          DR_SUB: begin
            if (sts.base_match) begin
              state_nxt = S_MUL;
            end else if (sts.slot_free) begin
              state_nxt = S_IDLE;
            end
          end
          DR_INS: begin
            if (sts.slot_free) begin
              state_nxt = S_TAIL;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_TAIL: begin
        if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_base = in_valid;
      end
      S_MUL: cmd.mul_en = 1'b1;
      S_ADD: cmd.add_en = 1'b1;
      S_DECIDE: begin
        // plain copy once no edit applies
        if (!sts.lt_mis && !sts.lt_ins && !sts.lt_del && sts.slot_free) begin
          cmd.emit_en   = 1'b1;
          cmd.emit_kind = KIND_COPY;
          cmd.emit_last = 1'b1;
        end
      end
      S_PICK: begin
        unique case (mode_r)
          DR_SUB: begin
            if (!sts.base_match && sts.slot_free) begin
              cmd.emit_en   = 1'b1;
              cmd.emit_rand = 1'b1;
              cmd.emit_kind = KIND_SUB;
              cmd.emit_last = 1'b1;
            end
          end
          DR_INS: begin
            if (sts.slot_free) begin
              cmd.emit_en   = 1'b1;
              cmd.emit_rand = 1'b1;
              cmd.emit_kind = KIND_INS;
            end
          end
          default: ;
        endcase
      end
      S_TAIL: begin
        if (sts.slot_free) begin
          cmd.emit_en   = 1'b1;
          cmd.emit_kind = KIND_COPY;
          cmd.emit_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  `NEI_ASSERT_NEXT(a_mul_then_add, clk, rst_n, state_r == S_MUL, state_r == S_ADD)
  `NEI_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_r == S_MUL && mode_r == DR_FIRST)
  `NEI_ASSERT_HOLDS(a_tail_after_ins, clk, rst_n, state_r == S_TAIL, mode_r == DR_INS)

endmodule

/* rtl/nucleotide_error_injector.sv */
// ----------------------------------------------------------------------------
// Nucleotide error injector
// Injects substitution, insertion and deletion errors into a base stream
// using a 48-bit linear congruential generator and cumulative thresholds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one ASCII base per item. Result
//   channel out_valid/out_ready carries zero, one or two items per input:
//   a substituted base, an inserted random base followed by the original,
//   nothing for a deletion, or the original copied.
//   One item is in work at a time. Each generator draw is the
//   32x32 multiply, then the 48-bit add. A copy or a deletion runs a draw
//   and the decision; a substitution adds a draw and the pick, plus a
//   draw per retry; an insertion adds a draw, the pick and the tail.
//   out_valid rises from the output register after the decision for a copy
//   and after the pick for a substitution or an inserted base; the original
//   follows the inserted base in the next cycle when the receiver is ready.
//   Results leave through a one-entry output register; while the receiver
//   stalls, the controller holds a pending result; when idle it accepts items.
//   Configuration writes on cfg_wr_en/cfg_index/cfg_data are taken at once;
//   a seed write reloads the generator. Write them only while idle.
//   Synchronous reset clears the limits, loads the seed-zero generator
//   state and empties the output register.
// ----------------------------------------------------------------------------
module nucleotide_error_injector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [nei_pkg::BASE_W-1:0]     in_base_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nei_pkg::BASE_W-1:0]     out_base_out,
  output logic [nei_pkg::KIND_W-1:0]     out_edit_kind,
  output logic                           out_run_end,
  input  logic                           cfg_wr_en,
  input  logic [nei_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nei_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nei_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  nei_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nei_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_base_in    (in_base_in),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_base_out  (out_base_out),
    .out_edit_kind (out_edit_kind),
    .out_run_end   (out_run_end)
  );

endmodule
